// ===== src/svm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg: shared types and codes for the sprite VM instruction executor
// Sequencer step codes, long-operation kinds, item modes and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package svm_pkg;

	localparam int ADDR_W    = 12;
	localparam int MEM_BYTES = 4096;

	// sequencer steps (controller state codes, also the datapath command)
	localparam logic [4:0] U_CLR    = 5'd0;
	localparam logic [4:0] U_IDLE   = 5'd1;
	localparam logic [4:0] U_RDX    = 5'd2;
	localparam logic [4:0] U_RDY    = 5'd3;
	localparam logic [4:0] U_EXEC   = 5'd4;
	localparam logic [4:0] U_FLAG   = 5'd5;
	localparam logic [4:0] U_BCD    = 5'd6;
	localparam logic [4:0] U_STO_RD = 5'd7;
	localparam logic [4:0] U_STO_WR = 5'd8;
	localparam logic [4:0] U_LD_RD  = 5'd9;
	localparam logic [4:0] U_LD_WR  = 5'd10;
	localparam logic [4:0] U_DR_MEM = 5'd11;
	localparam logic [4:0] U_DR_RD0 = 5'd12;
	localparam logic [4:0] U_DR_RD1 = 5'd13;
	localparam logic [4:0] U_DR_WR0 = 5'd14;
	localparam logic [4:0] U_DR_WR1 = 5'd15;
	localparam logic [4:0] U_DONE   = 5'd16;

	// follow-up work after the execute step
	localparam logic [2:0] K_DONE = 3'd0;
	localparam logic [2:0] K_FLAG = 3'd1;
	localparam logic [2:0] K_BCD  = 3'd2;
	localparam logic [2:0] K_STO  = 3'd3;
	localparam logic [2:0] K_LD   = 3'd4;
	localparam logic [2:0] K_DRAW = 3'd5;
	localparam logic [2:0] K_CLR  = 3'd6;

	localparam logic [1:0] MODE_EXEC = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	typedef struct packed {
		logic [4:0] uop;
		logic       accept;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       loop_last;
		logic       row_ok;
		logic       clr_last;
	} sts_t;

endpackage

// ===== src/svm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the contents.
// ----------------------------------------------------------------------------
module svm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/svm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ctrl: sequencer for the sprite VM executor
// Steps each item through operand reads, execute and any multi-cycle tail.
// ----------------------------------------------------------------------------
module svm_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  svm_pkg::sts_t sts,
	output svm_pkg::cmd_t cmd,
	output logic         busy,
	output logic         done
);
	import svm_pkg::*;

	logic [4:0] state_q, state_d;
	logic       boot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_CLR;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == U_CLR && sts.clr_last) begin
				boot_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			U_CLR: begin
				if (sts.clr_last) state_d = boot_q ? U_IDLE : U_DONE;
			end
			U_IDLE: begin
				if (start) state_d = U_RDX;
			end
			U_RDX:  state_d = U_RDY;
			U_RDY:  state_d = U_EXEC;
			U_EXEC: begin
				case (sts.kind)
					K_FLAG:  state_d = U_FLAG;
					K_BCD:   state_d = U_BCD;
					K_STO:   state_d = U_STO_RD;
					K_LD:    state_d = U_LD_RD;
					K_DRAW:  state_d = U_DR_MEM;
					K_CLR:   state_d = U_CLR;
					default: state_d = U_DONE;
				endcase
			end
			U_FLAG: state_d = U_DONE;
			U_BCD: begin
				if (sts.loop_last) state_d = U_DONE;
			end
			U_STO_RD: state_d = U_STO_WR;
			U_STO_WR: state_d = sts.loop_last ? U_DONE : U_STO_RD;
			U_LD_RD:  state_d = U_LD_WR;
			U_LD_WR:  state_d = sts.loop_last ? U_DONE : U_LD_RD;
			U_DR_MEM: state_d = sts.row_ok ? U_DR_RD0 : U_FLAG;
			U_DR_RD0: state_d = U_DR_RD1;
			U_DR_RD1: state_d = U_DR_WR0;
			U_DR_WR0: state_d = U_DR_WR1;
			U_DR_WR1: state_d = U_DR_MEM;
			U_DONE:   state_d = U_IDLE;
			default:  state_d = U_IDLE;
		endcase
	end

	assign busy       = state_q != U_IDLE;
	assign done       = state_q == U_DONE;
	assign cmd.uop    = state_q;
	assign cmd.accept = start && state_q == U_IDLE;

endmodule

// ===== src/svm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_datapath: machine state and execute logic of the sprite VM
// Register file, PC, index, stack, timers, main memory and frame buffer.
// ----------------------------------------------------------------------------
module svm_datapath #(
	parameter int DISPLAY_WIDTH  = 64,
	parameter int DISPLAY_HEIGHT = 32,
	parameter int FONT_BASE      = 80,
	parameter int STACK_DEPTH    = 16,
	parameter int PROGRAM_START  = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  svm_pkg::cmd_t cmd,
	output svm_pkg::sts_t sts,
	input  logic [1:0]    mode,
	input  logic [15:0]   opcode,
	input  logic [15:0]   key_state,
	input  logic [7:0]    random_byte,
	input  logic [11:0]   address,
	input  logic [7:0]    write_data,
	output logic [11:0]   program_counter,
	output logic [11:0]   index_address,
	output logic [7:0]    read_data,
	output logic          waiting_for_key,
	output logic          sound_active
);
	import svm_pkg::*;

	localparam int FB  = DISPLAY_WIDTH * DISPLAY_HEIGHT / 8;
	localparam int FBW = $clog2(FB);
	localparam int PW  = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT);
	localparam int SPW = $clog2(STACK_DEPTH);

	function automatic logic [7:0] wrap8(input logic [7:0] v, input logic [7:0] m);
		logic [7:0] r;
		r = v;
		for (int i = 0; i < 8; i++) begin
			if (r >= m) r = r - m;
		end
		return r;
	endfunction

	function automatic logic [7:0] random_mask(input logic [7:0] r, input logic [7:0] m);
		return r & m;
	endfunction

	// latched item
	logic [1:0]  mode_q;
	logic [15:0] op_q, keys_q;
	logic [7:0]  rnd_q, wdata_q;
	logic [11:0] addr_q;

	// control state
	logic [11:0]    pc_q, idx_q;
	logic [SPW-1:0] sp_q;
	logic [7:0]     dt_q, st_q;
	logic [15:0]    vvalid_q;
	logic           vrdv_q;
	logic [3:0]     cnt_q;
	logic [FBW-1:0] clr_q;
	logic           wait_q;

	// payload
	logic [11:0]    stack_q [STACK_DEPTH];
	logic [7:0]     vx_q, line_q, f0_q, f1_q, x0_q, y0_q;
	logic [3:0]     bcd_q [3];
	logic           flag_q, hit_q;
	logic [FBW-1:0] b0_q;
	logic [2:0]     off_q;

	// memories
	logic           v_we;
	logic [3:0]     v_wa, v_ra;
	logic [7:0]     v_wd, v_rdata, vrd;
	logic           m_we;
	logic [11:0]    m_wa, m_ra;
	logic [7:0]     m_wd, m_rdata;
	logic           f_we;
	logic [FBW-1:0] f_wa, f_ra;
	logic [7:0]     f_wd, f_rdata;

	svm_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
		.clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rdata)
	);
	svm_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rdata)
	);
	svm_ram #(.WIDTH(8), .DEPTH(FB)) u_frame (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rdata)
	);

	// opcode fields
	logic [3:0]  hi4, x, y, n;
	logic [7:0]  kk;
	logic [11:0] nnn;
	assign hi4 = op_q[15:12];
	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign kk  = op_q[7:0];
	assign nnn = op_q[11:0];

	// registers never written read as zero
	assign vrd = vrdv_q ? v_rdata : 8'h00;

	// execute decode
	logic [7:0]     vx, vy;
	logic [8:0]     sum9;
	logic [3:0]     key_idx;
	logic           key_any, held;
	logic [11:0]    pc2, pc_x, idx_x;
	logic [2:0]     kind_x;
	logic           xwe, flag_x, wait_x, set_dt, set_st, push, pop;
	logic [7:0]     xwd;
	logic [SPW-1:0] sp_inc, sp_dec;
	logic [1:0]     bh;
	logic [6:0]     brem;
	logic [14:0]    bprod;
	logic [3:0]     btens, bones;

	assign vx     = vx_q;
	assign vy     = vrd;
	assign sum9   = {1'b0, vx} + {1'b0, vy};
	assign held   = (vx[7:4] == 4'h0) && keys_q[vx[3:0]];
	assign pc2    = pc_q + 12'd2;
	assign sp_inc = (sp_q == SPW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SPW'(STACK_DEPTH - 1) : sp_q - 1'b1;

	assign bh    = (vx >= 8'd200) ? 2'd2 : (vx >= 8'd100) ? 2'd1 : 2'd0;
	assign brem  = 7'(vx - ((bh == 2'd2) ? 8'd200 : (bh == 2'd1) ? 8'd100 : 8'd0));
	assign bprod = 15'(brem) * 15'd205;
	assign btens = bprod[14:11];
	assign bones = 4'(brem - 7'({3'b000, btens}) * 7'd10);

	always_comb begin
		key_idx = 4'h0;
		key_any = |keys_q;
		for (int i = 15; i >= 0; i--) begin
			if (keys_q[i]) key_idx = 4'(i);
		end
	end

	always_comb begin
		pc_x   = pc2;
		idx_x  = idx_q;
		kind_x = K_DONE;
		xwe    = 1'b0;
		xwd    = vy;
		flag_x = 1'b0;
		wait_x = 1'b0;
		set_dt = 1'b0;
		set_st = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		unique case (hi4)
			4'h0: begin
				if (op_q == 16'h00E0) kind_x = K_CLR;
				else if (op_q == 16'h00EE) begin
					pop  = 1'b1;
					pc_x = stack_q[sp_dec];
				end
			end
			4'h1: pc_x = nnn;
			4'h2: begin
				push = 1'b1;
				pc_x = nnn;
			end
			4'h3: if (vx == kk) pc_x = pc2 + 12'd2;
			4'h4: if (vx != kk) pc_x = pc2 + 12'd2;
			4'h5: if (n == 4'h0 && vx == vy) pc_x = pc2 + 12'd2;
			4'h6: begin
				xwe = 1'b1;
				xwd = kk;
			end
			4'h7: begin
				xwe = 1'b1;
				xwd = vx + kk;
			end
			4'h8: begin
				xwe = 1'b1;
				case (n)
					4'h0: xwd = vy;
					4'h1: xwd = vx | vy;
					4'h2: xwd = vx & vy;
					4'h3: xwd = vx ^ vy;
					4'h4: begin
						xwd = sum9[7:0];
						flag_x = sum9[8];
						kind_x = K_FLAG;
					end
					4'h5: begin
						xwd = vx - vy;
						flag_x = vx > vy;
						kind_x = K_FLAG;
					end
					4'h6: begin
						xwd = {1'b0, vx[7:1]};
						flag_x = vx[0];
						kind_x = K_FLAG;
					end
					4'h7: begin
						xwd = vy - vx;
						flag_x = vy > vx;
						kind_x = K_FLAG;
					end
					4'hE: begin
						xwd = {vx[6:0], 1'b0};
						flag_x = vx[7];
						kind_x = K_FLAG;
					end
					default: xwe = 1'b0;
				endcase
			end
			4'h9: if (n == 4'h0 && vx != vy) pc_x = pc2 + 12'd2;
			4'hA: idx_x = nnn;
			4'hB: pc_x = nnn + {4'h0, vx};
			4'hC: begin
				xwe = 1'b1;
				xwd = random_mask(rnd_q, kk);
			end
			4'hD: kind_x = (n == 4'h0) ? K_FLAG : K_DRAW;
			4'hE: begin
				if (kk == 8'h9E && held) pc_x = pc2 + 12'd2;
				else if (kk == 8'hA1 && !held) pc_x = pc2 + 12'd2;
			end
			4'hF: begin
				case (kk)
					8'h07: begin
						xwe = 1'b1;
						xwd = dt_q;
					end
					8'h0A: begin
						if (key_any) begin
							xwe = 1'b1;
							xwd = {4'h0, key_idx};
						end else begin
							pc_x   = pc_q;
							wait_x = 1'b1;
						end
					end
					8'h15: set_dt = 1'b1;
					8'h18: set_st = 1'b1;
					8'h1E: idx_x = idx_q + {4'h0, vx};
					8'h29: idx_x = 12'(FONT_BASE) + {6'h00, vx[3:0], 2'b00} + {8'h00, vx[3:0]};
					8'h33: kind_x = K_BCD;
					8'h55: kind_x = K_STO;
					8'h65: kind_x = K_LD;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// sprite row geometry
	logic [7:0]     yr, rem, keep;
	logic [PW-1:0]  pix;
	logic [FBW-1:0] b0_d, b1;
	logic [15:0]    win;
	logic [7:0]     hi, lo;
	assign yr   = y0_q + {4'h0, cnt_q};
	assign pix  = PW'(int'(yr) * DISPLAY_WIDTH + int'(x0_q));
	assign b0_d = pix[PW-1:3];
	assign b1   = b0_q + 1'b1;
	assign rem  = 8'(DISPLAY_WIDTH) - x0_q;
	assign keep = (rem >= 8'd8) ? 8'hFF : ~(8'hFF >> rem[2:0]);
	assign win  = {line_q, 8'h00} >> off_q;
	assign hi   = win[15:8];
	assign lo   = win[7:0];

	// memory port steering
	always_comb begin
		v_we = 1'b0;
		v_wa = x;
		v_wd = xwd;
		m_we = 1'b0;
		m_wa = idx_q + {8'h00, cnt_q};
		m_wd = vrd;
		f_we = 1'b0;
		f_wa = b0_q;
		f_wd = f0_q ^ hi;
		f_ra = b0_q;
		case (cmd.uop)
			U_RDX:    v_ra = (hi4 == 4'hB) ? 4'h0 : x;
			U_STO_RD: v_ra = cnt_q;
			default:  v_ra = y;
		endcase
		case (cmd.uop)
			U_EXEC: begin
				v_we = (mode_q == MODE_EXEC) && xwe;
				m_we = mode_q == MODE_LOAD;
				m_wa = addr_q;
				m_wd = wdata_q;
				f_ra = addr_q[FBW-1:0];
			end
			U_FLAG: begin
				v_we = 1'b1;
				v_wa = 4'hF;
				v_wd = {7'h00, flag_q};
			end
			U_LD_WR: begin
				v_we = 1'b1;
				v_wa = cnt_q;
				v_wd = m_rdata;
			end
			U_BCD: begin
				m_we = 1'b1;
				m_wd = {4'h0, bcd_q[cnt_q[1:0]]};
			end
			U_STO_WR: m_we = 1'b1;
			U_CLR: begin
				f_we = 1'b1;
				f_wa = clr_q;
				f_wd = 8'h00;
			end
			U_DR_RD0: f_ra = b0_d;
			U_DR_RD1: f_ra = b1;
			U_DR_WR0: f_we = 1'b1;
			U_DR_WR1: begin
				f_we = lo != 8'h00;
				f_wa = b1;
				f_wd = f1_q ^ lo;
			end
			default: ;
		endcase
	end
	assign m_ra = idx_q + {8'h00, cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 12'(PROGRAM_START);
			idx_q    <= '0;
			sp_q     <= '0;
			dt_q     <= '0;
			st_q     <= '0;
			vvalid_q <= '0;
			vrdv_q   <= 1'b0;
			cnt_q    <= '0;
			clr_q    <= '0;
			wait_q   <= 1'b0;
		end else begin
			vrdv_q <= vvalid_q[v_ra];
			if (v_we) vvalid_q[v_wa] <= 1'b1;
			if (cmd.uop == U_CLR) begin
				clr_q <= (clr_q == FBW'(FB - 1)) ? '0 : clr_q + 1'b1;
			end
			case (cmd.uop)
				U_EXEC: begin
					cnt_q  <= '0;
					wait_q <= (mode_q == MODE_EXEC) && wait_x;
					if (mode_q == MODE_EXEC) begin
						pc_q  <= pc_x;
						idx_q <= idx_x;
						if (push) sp_q <= sp_inc;
						if (pop) sp_q <= sp_dec;
						if (set_dt) dt_q <= vx;
						if (set_st) st_q <= vx;
					end else if (mode_q == MODE_TICK) begin
						if (dt_q != 8'h00) dt_q <= dt_q - 1'b1;
						if (st_q != 8'h00) st_q <= st_q - 1'b1;
					end
				end
				U_BCD, U_STO_WR, U_LD_WR, U_DR_WR1: cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			op_q    <= opcode;
			keys_q  <= key_state;
			rnd_q   <= random_byte;
			addr_q  <= address;
			wdata_q <= write_data;
		end
		case (cmd.uop)
			U_RDY: vx_q <= vrd;
			U_EXEC: begin
				flag_q   <= flag_x;
				hit_q    <= 1'b0;
				x0_q     <= wrap8(vx, 8'(DISPLAY_WIDTH));
				y0_q     <= wrap8(vy, 8'(DISPLAY_HEIGHT));
				bcd_q[0] <= {2'b00, bh};
				bcd_q[1] <= btens;
				bcd_q[2] <= bones;
				if (push && mode_q == MODE_EXEC) stack_q[sp_q] <= pc2;
			end
			U_DR_MEM: flag_q <= hit_q;
			U_DR_RD0: begin
				line_q <= m_rdata & keep;
				b0_q   <= b0_d;
				off_q  <= pix[2:0];
			end
			U_DR_RD1: f0_q <= f_rdata;
			U_DR_WR0: begin
				f1_q  <= f_rdata;
				hit_q <= hit_q | (|(f0_q & hi)) | (|(f_rdata & lo));
			end
			default: ;
		endcase
	end

	assign sts.kind      = (mode_q == MODE_EXEC) ? kind_x : K_DONE;
	assign sts.loop_last = (cmd.uop == U_BCD) ? (cnt_q == 4'd2) : (cnt_q == x);
	assign sts.row_ok    = (cnt_q < n) && (yr < 8'(DISPLAY_HEIGHT));
	assign sts.clr_last  = clr_q == FBW'(FB - 1);

	assign program_counter = pc_q;
	assign index_address   = idx_q;
	assign read_data       = (mode_q == MODE_READ && addr_q < 12'(FB)) ? f_rdata : 8'h00;
	assign waiting_for_key = wait_q;
	assign sound_active    = st_q != 8'h00;

endmodule

// ===== src/sprite_vm_instruction_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_vm_instruction_executor: 8-bit sprite VM instruction executor
// Runs one instruction, memory load, timer tick or display read per item.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows for
// one cycle with done high and must be captured then, since the receiver
// cannot stall. After reset the frame buffer is swept clear, one byte a
// cycle over all DISPLAY_WIDTH*DISPLAY_HEIGHT/8 bytes (256 by default), with
// busy high. Simple items read two registers and execute before done, and the
// next item may start in the cycle after done; ALU ops with a flag add a VF
// write, BCD writes three digits, block load/store reads and writes each of
// V0..Vx, a sprite draw reads the sprite byte and two frame bytes and writes
// them back per visible row, then writes VF (height 0 only writes VF), and a
// screen clear takes one sweep of the frame buffer. These steps come from the
// single-ported register file, main memory and frame buffer, each with a registered read.
// ----------------------------------------------------------------------------
module sprite_vm_instruction_executor #(
	parameter int DISPLAY_WIDTH  = 64,
	parameter int DISPLAY_HEIGHT = 32,
	parameter int FONT_BASE      = 80,
	parameter int STACK_DEPTH    = 16,
	parameter int PROGRAM_START  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] opcode,
	input  logic [15:0] key_state,
	input  logic [7:0]  random_byte,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [11:0] program_counter,
	output logic [11:0] index_address,
	output logic [7:0]  read_data,
	output logic        waiting_for_key,
	output logic        sound_active
);
	import svm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	svm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	svm_datapath #(
		.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
		.FONT_BASE(FONT_BASE), .STACK_DEPTH(STACK_DEPTH),
		.PROGRAM_START(PROGRAM_START)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .opcode(opcode), .key_state(key_state),
		.random_byte(random_byte), .address(address), .write_data(write_data),
		.program_counter(program_counter), .index_address(index_address),
		.read_data(read_data), .waiting_for_key(waiting_for_key),
		.sound_active(sound_active)
	);

endmodule

// ===== dv/sprite_vm_instruction_executor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_vm_instruction_executor_tb: self-checking bench for the VM executor
// Builds a directed and then a random item stream up front and runs each item
// through a bench-side VM model as it is built. The clocked driver issues the
// items with random gaps, none within a quiet window. The clocked monitor
// checks every done pulse field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module sprite_vm_instruction_executor_tb;

	localparam int NUM_ITEMS  = 1950;
	localparam int STALL_MAX  = 4000;
	localparam int IDLE_PCT   = 36;
	localparam int QUIET_LO   = 900;
	localparam int QUIET_HI   = 1200;
	localparam int DISP_W     = 64;
	localparam int DISP_H     = 32;
	localparam int FONT_ADDR  = 80;
	localparam int PIX_BYTES  = DISP_W * DISP_H / 8;

	// instruction groups (top nibble)
	localparam logic [3:0] G_SYS  = 4'h0;
	localparam logic [3:0] G_JP   = 4'h1;
	localparam logic [3:0] G_CALL = 4'h2;
	localparam logic [3:0] G_SE   = 4'h3;
	localparam logic [3:0] G_SNE  = 4'h4;
	localparam logic [3:0] G_SER  = 4'h5;
	localparam logic [3:0] G_LDK  = 4'h6;
	localparam logic [3:0] G_ADDK = 4'h7;
	localparam logic [3:0] G_ALU  = 4'h8;
	localparam logic [3:0] G_SNER = 4'h9;
	localparam logic [3:0] G_LDI  = 4'hA;
	localparam logic [3:0] G_JPV  = 4'hB;
	localparam logic [3:0] G_RND  = 4'hC;
	localparam logic [3:0] G_DRW  = 4'hD;
	localparam logic [3:0] G_KEY  = 4'hE;
	localparam logic [3:0] G_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [3:0] A_MOV  = 4'h0;
	localparam logic [3:0] A_OR   = 4'h1;
	localparam logic [3:0] A_AND  = 4'h2;
	localparam logic [3:0] A_XOR  = 4'h3;
	localparam logic [3:0] A_ADD  = 4'h4;
	localparam logic [3:0] A_SUB  = 4'h5;
	localparam logic [3:0] A_SHR  = 4'h6;
	localparam logic [3:0] A_SUBN = 4'h7;
	localparam logic [3:0] A_SHL  = 4'hE;

	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	localparam logic [7:0] F_GETDT = 8'h07;
	localparam logic [7:0] F_WAIT  = 8'h0A;
	localparam logic [7:0] F_SETDT = 8'h15;
	localparam logic [7:0] F_SETST = 8'h18;
	localparam logic [7:0] F_ADDI  = 8'h1E;
	localparam logic [7:0] F_FONT  = 8'h29;
	localparam logic [7:0] F_BCD   = 8'h33;
	localparam logic [7:0] F_STORE = 8'h55;
	localparam logic [7:0] F_LOAD  = 8'h65;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] opcode;
		logic [15:0] keys;
		logic [7:0]  rnd;
		logic [11:0] addr;
		logic [7:0]  wdata;
		logic [11:0] pc;
		logic [11:0] idx;
		logic [7:0]  rd;
		logic        wait_k;
		logic        snd;
	} vm_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = '0;
	logic [15:0] opcode = '0;
	logic [15:0] key_state = '0;
	logic [7:0]  random_byte = '0;
	logic [11:0] address = '0;
	logic [7:0]  write_data = '0;
	logic        done;
	logic [11:0] program_counter;
	logic [11:0] index_address;
	logic [7:0]  read_data;
	logic        waiting_for_key;
	logic        sound_active;

	// VM shadow state
	logic [7:0]  vreg [16];
	logic [11:0] vm_pc;
	logic [11:0] vm_idx;
	logic [11:0] call_stack [16];
	bit          call_written [16];
	logic [3:0]  call_sp;
	logic [7:0]  delay_t;
	logic [7:0]  sound_t;
	logic [7:0]  ram [4096];
	bit          ram_written [4096];
	bit          pixels [DISP_W*DISP_H];

	vm_item_t pending_items [$];
	vm_item_t expected_results [$];
	vm_item_t cur_item;
	bit       taken = 0;
	int       items_built = 0;
	int       items_issued = 0;
	int       items_accepted = 0;
	int       errors = 0;
	int       stall_cnt = 0;

	sprite_vm_instruction_executor u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .opcode(opcode), .key_state(key_state),
		.random_byte(random_byte), .address(address), .write_data(write_data),
		.done(done), .program_counter(program_counter),
		.index_address(index_address), .read_data(read_data),
		.waiting_for_key(waiting_for_key), .sound_active(sound_active)
	);

	always #10 clk = ~clk;

	task automatic ram_put(logic [11:0] a, logic [7:0] v);
		ram[a] = v;
		ram_written[a] = 1;
	endtask

	task automatic step_vm(inout vm_item_t it);
		logic [3:0]  x, y, n;
		logic [7:0]  kk, vx, vy, line, f;
		logic [11:0] nnn;
		logic [8:0]  sum;
		int          x0, y0, p;
		bit          hit, found;
		x = it.opcode[11:8];
		y = it.opcode[7:4];
		n = it.opcode[3:0];
		kk = it.opcode[7:0];
		nnn = it.opcode[11:0];
		vx = vreg[x];
		vy = vreg[y];
		it.rd = '0;
		it.wait_k = 1'b0;
		case (it.mode)
			svm_pkg::MODE_EXEC: begin
				vm_pc = vm_pc + 12'd2;
				case (it.opcode[15:12])
					G_SYS: begin
						if (it.opcode == OP_CLS) begin
							foreach (pixels[i]) pixels[i] = 0;
						end else if (it.opcode == OP_RET) begin
							call_sp = call_sp - 4'd1;
							vm_pc = call_stack[call_sp];
						end
					end
					G_JP: vm_pc = nnn;
					G_CALL: begin
						call_stack[call_sp] = vm_pc;
						call_written[call_sp] = 1;
						call_sp = call_sp + 4'd1;
						vm_pc = nnn;
					end
					G_SE: if (vx == kk) vm_pc = vm_pc + 12'd2;
					G_SNE: if (vx != kk) vm_pc = vm_pc + 12'd2;
					G_SER: if (n == 0 && vx == vy) vm_pc = vm_pc + 12'd2;
					G_LDK: vreg[x] = kk;
					G_ADDK: vreg[x] = vx + kk;
					G_ALU: begin
						case (n)
							A_MOV: vreg[x] = vy;
							A_OR:  vreg[x] = vx | vy;
							A_AND: vreg[x] = vx & vy;
							A_XOR: vreg[x] = vx ^ vy;
							A_ADD: begin
								sum = vx + vy;
								vreg[x] = sum[7:0];
								vreg[15] = {7'd0, sum[8]};
							end
							A_SUB: begin
								f = (vx > vy) ? 8'd1 : 8'd0;
								vreg[x] = vx - vy;
								vreg[15] = f;
							end
							A_SHR: begin
								vreg[x] = vx >> 1;
								vreg[15] = {7'd0, vx[0]};
							end
							A_SUBN: begin
								f = (vy > vx) ? 8'd1 : 8'd0;
								vreg[x] = vy - vx;
								vreg[15] = f;
							end
							A_SHL: begin
								vreg[x] = vx << 1;
								vreg[15] = {7'd0, vx[7]};
							end
							default: ;
						endcase
					end
					G_SNER: if (n == 0 && vx != vy) vm_pc = vm_pc + 12'd2;
					G_LDI: vm_idx = nnn;
					G_JPV: vm_pc = nnn + {4'd0, vreg[0]};
					G_RND: vreg[x] = it.rnd & kk;
					G_DRW: begin
						x0 = vx % DISP_W;
						y0 = vy % DISP_H;
						hit = 0;
						for (int r = 0; r < n; r++) begin
							line = ram[vm_idx + 12'(r)];
							if (y0 + r >= DISP_H) break;
							for (int c = 0; c < 8; c++) begin
								if (x0 + c >= DISP_W) break;
								if (line[7-c]) begin
									p = (y0 + r) * DISP_W + x0 + c;
									if (pixels[p]) hit = 1;
									pixels[p] = !pixels[p];
								end
							end
						end
						vreg[15] = {7'd0, hit};
					end
					G_KEY: begin
						if (kk == KEY_DOWN && vx < 16 && it.keys[vx[3:0]])
							vm_pc = vm_pc + 12'd2;
						else if (kk == KEY_UP && !(vx < 16 && it.keys[vx[3:0]]))
							vm_pc = vm_pc + 12'd2;
					end
					G_MISC: begin
						case (kk)
							F_GETDT: vreg[x] = delay_t;
							F_WAIT: begin
								found = 0;
								for (int i = 0; i < 16; i++)
									if (!found && it.keys[i]) begin
										vreg[x] = 8'(i);
										found = 1;
									end
								if (!found) begin
									vm_pc = vm_pc - 12'd2;
									it.wait_k = 1'b1;
								end
							end
							F_SETDT: delay_t = vx;
							F_SETST: sound_t = vx;
							F_ADDI:  vm_idx = vm_idx + {4'd0, vx};
							F_FONT:  vm_idx = 12'(FONT_ADDR + 5 * vx[3:0]);
							F_BCD: begin
								ram_put(vm_idx, vx / 100);
								ram_put(vm_idx + 12'd1, (vx / 10) % 10);
								ram_put(vm_idx + 12'd2, vx % 10);
							end
							F_STORE: for (int i = 0; i <= x; i++) ram_put(vm_idx + 12'(i), vreg[i]);
							F_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = ram[vm_idx + 12'(i)];
							default: ;
						endcase
					end
					default: ;
				endcase
			end
			svm_pkg::MODE_LOAD: ram_put(it.addr, it.wdata);
			svm_pkg::MODE_TICK: begin
				if (delay_t != 0) delay_t = delay_t - 8'd1;
				if (sound_t != 0) sound_t = sound_t - 8'd1;
			end
			default: begin
				if (it.addr < PIX_BYTES)
					for (int b = 0; b < 8; b++) it.rd = {it.rd[6:0], pixels[it.addr*8 + b]};
			end
		endcase
		it.pc = vm_pc;
		it.idx = vm_idx;
		it.snd = (sound_t != 0);
	endtask

	task automatic add_item(vm_item_t it);
		step_vm(it);
		pending_items.push_back(it);
		items_built++;
	endtask

	task automatic add_mode(logic [1:0] m, logic [11:0] a);
		vm_item_t it;
		it.mode = m;
		it.opcode = 16'($urandom);
		it.keys = 16'($urandom);
		it.rnd = 8'($urandom);
		it.addr = a;
		it.wdata = 8'($urandom);
		add_item(it);
	endtask

	// fill unwritten bytes in a range with loads so reads always see known data
	task automatic cover_ram(logic [11:0] base, int count);
		for (int i = 0; i < count; i++)
			if (!ram_written[base + 12'(i)]) add_mode(svm_pkg::MODE_LOAD, base + 12'(i));
	endtask

	task automatic add_exec(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
		vm_item_t it;
		if (op == OP_RET && !call_written[call_sp - 4'd1])
			op = {G_CALL, 12'($urandom)};
		if (op[15:12] == G_DRW) cover_ram(vm_idx, op[3:0]);
		if (op[15:12] == G_MISC && op[7:0] == F_LOAD) cover_ram(vm_idx, op[11:8] + 1);
		it.mode = svm_pkg::MODE_EXEC;
		it.opcode = op;
		it.keys = keys;
		it.rnd = rnd;
		it.addr = 12'($urandom);
		it.wdata = 8'($urandom);
		add_item(it);
	endtask

	function automatic logic [15:0] rand_keys();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return 16'(1) << $urandom_range(0, 15);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_op();
		logic [15:0] op;
		logic [3:0]  alu_n [9] = '{A_MOV, A_OR, A_AND, A_XOR, A_ADD, A_SUB, A_SHR, A_SUBN, A_SHL};
		logic [7:0]  f_kk [9] = '{F_GETDT, F_WAIT, F_SETDT, F_SETST, F_ADDI, F_FONT, F_BCD,
			F_STORE, F_LOAD};
		op = 16'($urandom);
		case (op[15:12])
			G_SYS: begin
				case ($urandom_range(0, 7))
					0: op = OP_CLS;
					1, 2, 3: op = OP_RET;
					default: ;
				endcase
			end
			G_SER, G_SNER: if ($urandom_range(0, 4) != 0) op[3:0] = 4'h0;
			G_LDK: if ($urandom_range(0, 1) != 0) op[7:0] = 8'($urandom_range(0, 15));
			G_ALU: if ($urandom_range(0, 9) != 0) op[3:0] = alu_n[$urandom_range(0, 8)];
			G_DRW: if ($urandom_range(0, 4) != 0) op[3:0] = 4'($urandom_range(0, 5));
			G_KEY: if ($urandom_range(0, 9) != 0) op[7:0] = $urandom_range(0, 1) ? KEY_DOWN : KEY_UP;
			G_MISC: if ($urandom_range(0, 9) != 0) op[7:0] = f_kk[$urandom_range(0, 8)];
			default: ;
		endcase
		return op;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	initial begin
		foreach (vreg[i]) vreg[i] = '0;
		foreach (pixels[i]) pixels[i] = 0;
		vm_pc = 12'd512;
		vm_idx = '0;
		call_sp = '0;
		delay_t = '0;
		sound_t = '0;

		// directed: extremes, flags with x = F, undefined forms, clipping, waits
		add_exec(16'h6AFF, '0, 8'hFF);
		add_exec(16'h6B01, '0, 8'h00);
		add_exec(16'h8AB4, '0, 8'h00);
		add_exec(16'h6FC8, '0, 8'h00);
		add_exec(16'h6E40, '0, 8'h00);
		add_exec(16'h8FE4, '0, 8'h00);
		add_exec(16'h6A05, '0, 8'h00);
		add_exec(16'h6B09, '0, 8'h00);
		add_exec(16'h8AB5, '0, 8'h00);
		add_exec(16'h8AB7, '0, 8'h00);
		add_exec(16'h8AB6, '0, 8'h00);
		add_exec(16'h8ABE, '0, 8'h00);
		add_exec(16'h5AB1, '0, 8'h00);
		add_exec(16'h0123, '0, 8'h00);
		add_exec(16'h6C20, '0, 8'h00);
		add_exec(16'hEC9E, 16'hFFFF, 8'h00);
		add_exec(16'hECA1, 16'hFFFF, 8'h00);
		add_exec(16'hF00A, '0, 8'h00);
		add_exec(16'hF10A, 16'h8001, 8'h00);
		add_exec(16'h62AB, '0, 8'h00);
		add_exec(16'hF229, '0, 8'h00);
		add_exec(16'h6D3F, '0, 8'h00);
		add_exec(16'h6E1F, '0, 8'h00);
		add_exec(16'hAFF8, '0, 8'h00);
		add_exec(16'hDDEF, '0, 8'h00);
		add_exec(16'hDDE0, '0, 8'h00);
		add_mode(svm_pkg::MODE_READ, 12'd255);
		add_mode(svm_pkg::MODE_READ, 12'hFFF);
		add_exec(16'hF318, '0, 8'h00);
		add_mode(svm_pkg::MODE_TICK, '0);
		add_exec(16'hFC33, '0, 8'h00);
		add_exec(16'h2FFE, '0, 8'h00);
		add_exec(OP_RET, '0, 8'h00);
		add_exec(16'hBFFF, '0, 8'h00);
		add_exec(16'hFE55, '0, 8'h00);
		add_exec(16'hFE65, '0, 8'h00);
		add_exec(OP_CLS, '0, 8'h00);

		while (items_built < NUM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: add_mode(svm_pkg::MODE_LOAD, 12'($urandom));
				1: add_mode(svm_pkg::MODE_TICK, 12'($urandom));
				2: add_mode(svm_pkg::MODE_READ,
					$urandom_range(0, 7) ? 12'($urandom_range(0, PIX_BYTES - 1)) : 12'($urandom));
				default: add_exec(rand_op(), rand_keys(), 8'($urandom));
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (items_accepted == items_built && expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// driver: present the next item at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			taken = 0;
			if (pending_items.size() > 0 &&
				((items_issued >= QUIET_LO && items_issued < QUIET_HI) ||
				$urandom_range(0, 99) >= IDLE_PCT)) begin
				cur_item = pending_items.pop_front();
				items_issued++;
				mode <= cur_item.mode;
				opcode <= cur_item.opcode;
				key_state <= cur_item.keys;
				random_byte <= cur_item.rnd;
				address <= cur_item.addr;
				write_data <= cur_item.wdata;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, record accepted items, watch for a hang
	always @(posedge clk) begin
		vm_item_t e;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with no item outstanding", $time);
				end else begin
					e = expected_results.pop_front();
					check_field("program_counter", e.pc, program_counter);
					check_field("index_address", e.idx, index_address);
					check_field("read_data", e.rd, read_data);
					check_field("waiting_for_key", e.wait_k, waiting_for_key);
					check_field("sound_active", e.snd, sound_active);
				end
			end
			if (start && !busy) begin
				expected_results.push_back(cur_item);
				items_accepted++;
				taken = 1;
			end
			if (done || (start && !busy))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_MAX) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
